// ----- design/lrupr_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU page replacement package
// Shared types and fixed field widths for the controller and the datapath.
// ---------------------------------------------------------------------------
package lrupr_pkg;

    localparam int IN_PAGE_W   = 16;
    localparam int OUT_PAGE_W  = 16;
    localparam int FRAME_IDX_W = 2;
    localparam int COUNT_W     = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;   // latch the page and restart the frame scan
        logic issue;   // read the next frame from the page store
        logic update;  // apply the replacement decision and load the result
    } lrupr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_issue; // the frame being read is the last one
        logic out_busy;   // a result is held that has not been taken
    } lrupr_sts_t;

endpackage

// ----- design/lrupr_ram.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lrupr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/lrupr_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU page replacement controller
// Sequences acceptance, the frame scan, the compare tail and the update.
// ---------------------------------------------------------------------------
module lrupr_ctrl
    import lrupr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  lrupr_sts_t sts,
    output lrupr_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_UPDATE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (sts.last_issue) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!sts.out_busy) begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- design/lrupr_dpath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU page replacement datapath
// Page store, valid bits, recency ranks, scan compare and result register.
// ---------------------------------------------------------------------------
module lrupr_dpath
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = 4,
    parameter int PAGE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lrupr_cmd_t             cmd,
    output lrupr_sts_t             sts,
    input  logic [IN_PAGE_W-1:0]   s_page_number,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic                   m_hit,
    output logic [FRAME_IDX_W-1:0] m_frame_index,
    output logic                   m_evicted_valid,
    output logic [OUT_PAGE_W-1:0]  m_evicted_page,
    output logic [COUNT_W-1:0]     m_miss_count
);

    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PW = (PAGE_BITS < IN_PAGE_W) ? PAGE_BITS : IN_PAGE_W;
    localparam logic [FW-1:0] RANK_OLDEST = FW'(FRAMES - 1);
    localparam logic [FW-1:0] LAST_FRAME  = FW'(FRAMES - 1);

    logic [PW-1:0] page_reg;
    logic [FW-1:0] scan_cnt_reg;
    logic          cmp_valid_reg;
    logic [FW-1:0] cmp_idx_reg;
    logic          hit_found_reg;
    logic [FW-1:0] hit_slot_reg;
    logic [FW-1:0] hit_rank_reg;
    logic [FW-1:0] lru_slot_reg;
    logic          lru_valid_reg;
    logic [PW-1:0] lru_page_reg;
    logic [FRAMES-1:0] valid_reg;
    logic [FW-1:0] rank_reg [FRAMES];
    logic [COUNT_W-1:0] fault_total_reg;
    logic [COUNT_W-1:0] fault_total_next;

    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [FRAME_IDX_W-1:0] out_frame_reg;
    logic                   out_ev_valid_reg;
    logic [OUT_PAGE_W-1:0]  out_ev_page_reg;
    logic [COUNT_W-1:0]     out_count_reg;

    logic [PW-1:0]      rd_page;
    logic               cmp_match;
    logic               cmp_oldest;
    logic [FW-1:0]      slot;
    logic [FW-1:0]      old_rank;
    logic [FW+FRAME_IDX_W-1:0] slot_ext;

    lrupr_ram #(
        .WIDTH (PW),
        .DEPTH (FRAMES)
    ) u_page_ram (
        .aclk  (aclk),
        .we    (cmd.update && !hit_found_reg),
        .waddr (slot),
        .wdata (page_reg),
        .raddr (scan_cnt_reg),
        .rdata (rd_page)
    );

    // Compare stage: RAM read data is registered, so it lines up with the address held in cmp_idx_reg.
    assign cmp_match  = cmp_valid_reg && valid_reg[cmp_idx_reg] && (rd_page == page_reg);
    assign cmp_oldest = cmp_valid_reg && (rank_reg[cmp_idx_reg] == RANK_OLDEST);

    assign slot     = hit_found_reg ? hit_slot_reg : lru_slot_reg;
    assign old_rank = hit_found_reg ? hit_rank_reg : RANK_OLDEST;
    assign slot_ext = {{FRAME_IDX_W{1'b0}}, slot};

    assign fault_total_next = (fault_total_reg == COUNT_MAX) ? fault_total_reg
                                                             : fault_total_reg + COUNT_W'(1);

    assign sts.last_issue = (scan_cnt_reg == LAST_FRAME);
    assign sts.out_busy   = out_valid_reg && !m_ready;

    // Scan and capture registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_valid_reg <= 1'b0;
            hit_found_reg <= 1'b0;
            scan_cnt_reg  <= '0;
        end else begin
            cmp_valid_reg <= cmd.issue;
            if (cmd.start) begin
                scan_cnt_reg  <= '0;
                hit_found_reg <= 1'b0;
            end else begin
                if (cmd.issue) begin
                    scan_cnt_reg <= scan_cnt_reg + FW'(1);
                end
                if (cmp_match && !hit_found_reg) begin
                    hit_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            page_reg <= s_page_number[PW-1:0];
        end
        cmp_idx_reg <= scan_cnt_reg;
        if (cmp_match && !hit_found_reg) begin
            hit_slot_reg <= cmp_idx_reg;
            hit_rank_reg <= rank_reg[cmp_idx_reg];
        end
        if (cmp_oldest) begin
            lru_slot_reg  <= cmp_idx_reg;
            lru_valid_reg <= valid_reg[cmp_idx_reg];
            lru_page_reg  <= rd_page;
        end
    end

    // Frame state: valid bits, recency ranks and the fault counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg       <= '0;
            fault_total_reg <= '0;
            for (int i = 0; i < FRAMES; i++) begin
                rank_reg[i] <= FW'(FRAMES - 1 - i);
            end
        end else if (cmd.update) begin
            valid_reg[slot] <= 1'b1;
            if (!hit_found_reg) begin
                fault_total_reg <= fault_total_next;
            end
            for (int i = 0; i < FRAMES; i++) begin
                if (FW'(i) == slot) begin
                    rank_reg[i] <= '0;
                end else if (rank_reg[i] < old_rank) begin
                    rank_reg[i] <= rank_reg[i] + FW'(1);
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.update) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            out_hit_reg      <= hit_found_reg;
            out_frame_reg    <= slot_ext[FRAME_IDX_W-1:0];
            out_ev_valid_reg <= !hit_found_reg && lru_valid_reg;
            out_ev_page_reg  <= (!hit_found_reg && lru_valid_reg) ? OUT_PAGE_W'(lru_page_reg)
                                                                  : '0;
            out_count_reg    <= hit_found_reg ? fault_total_reg : fault_total_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_hit           = out_hit_reg;
    assign m_frame_index   = out_frame_reg;
    assign m_evicted_valid = out_ev_valid_reg;
    assign m_evicted_page  = out_ev_page_reg;
    assign m_miss_count    = out_count_reg;

endmodule

// ----- design/lru_page_replacement_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU page replacement
// Fully associative page frames under least-recently-used replacement.
// ---------------------------------------------------------------------------
// Items are taken one at a time: a new item is accepted only after the last
// one is updated. The page store has a single read port and the scan reads
// one frame per cycle.
// Reset: synchronous, active low. Frames come out empty, ranks put frame 0
// oldest so frames fill in index order, and the miss count is zero.
// The page store itself is not cleared; its valid bits cover it.
module lru_page_replacement_top
    import lrupr_pkg::*;
#(
    parameter int FRAMES    = 4,
    parameter int PAGE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [IN_PAGE_W-1:0]   s_page_number,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_hit,
    output logic [FRAME_IDX_W-1:0] m_frame_index,
    output logic                   m_evicted_valid,
    output logic [OUT_PAGE_W-1:0]  m_evicted_page,
    output logic [COUNT_W-1:0]     m_miss_count
);

    // The controller steps one item at a time through the scan of all frames,
    // the compare tail and the update. The update waits until the result
    // register is free, so an item is never lost.
    lrupr_cmd_t cmd;
    lrupr_sts_t sts;

    lrupr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the page store, the valid bits, the recency ranks
    // and the saturating fault counter, and registers each result item.
    lrupr_dpath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_page_number   (s_page_number),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_miss_count    (m_miss_count)
    );

    // Only one command is issued in any cycle.
    a_cmd_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.start, cmd.issue, cmd.update}))
        else $error("more than one controller command in a cycle");

    // An accepted item closes the input until its work is done.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice while an item was in flight");

    // An update always presents a result in the following cycle.
    a_update_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.update |=> m_valid)
        else $error("update did not produce a result item");

    // A hit never displaces a page.
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted_valid))
        else $error("result reports a hit and an eviction together");

endmodule

// ----- bench/tb_lru_page_replacement_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU page replacement testbench
// Drives page references into the block under random idling on both sides.
// A shadow copy of the frames predicts every result, and each result is
// checked field by field against the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module tb_lru_page_replacement_top;
    import lrupr_pkg::*;

    localparam int FRAMES       = 4;
    localparam int PAGE_BITS    = 16;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 3;
    // Even with the longest gaps and stalls on every item, a correct run stays
    // well inside this limit, which leaves a wide margin in hand.
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int RANDOM_ITEMS = 1300;
    // These quiet cycles after the last result outlast the path from an item to
    // its result, so they are ample to catch any stray extra one.
    localparam int SETTLE_CYCLES = FRAMES + 6;
    localparam int MAX_REPORTS   = 40;
    localparam int POOL_DEPTH    = 8;

    // Hand-picked references: empty frames fill in index order, a hit on every
    // frame, evictions chosen by recency, and the extremes of the page field.
    localparam logic [IN_PAGE_W-1:0] DIRECTED_PAGES [22] = '{
        16'h0000, 16'hFFFF, 16'h0000, 16'h1234, 16'hABCD, 16'hFFFF,
        16'h5555, 16'h0000, 16'hABCD, 16'h1234, 16'h5555, 16'h0000,
        16'hABCD, 16'h1234, 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE,
        16'h0001, 16'h8000, 16'hFFFE, 16'h7FFF
    };

    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [OUT_PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0]     miss_count;
    } page_outcome_t;

    // Shadow of the frame set. Every accepted item updates the shadow at once
    // and queues the outcome it predicts; results then retire that queue in
    // order, since the block answers items strictly one after another.
    class lru_frame_board;
        logic [PAGE_BITS-1:0] page_of [FRAMES];
        bit                   held [FRAMES];
        int unsigned          rank [FRAMES];
        logic [COUNT_W-1:0]   fault_total;
        page_outcome_t        expected_outcomes [$];
        int unsigned          failures;
        int unsigned          checked;
        int unsigned          hits;
        int unsigned          evictions;
        int unsigned          empty_fills;

        function new();
            for (int i = 0; i < FRAMES; i++) begin
                page_of[i] = '0;
                held[i]    = 1'b0;
                rank[i]    = FRAMES - 1 - i;
            end
            fault_total = '0;
            failures    = 0;
            checked     = 0;
            hits        = 0;
            evictions   = 0;
            empty_fills = 0;
        endfunction

        function void note_access(logic [IN_PAGE_W-1:0] page_in);
            page_outcome_t        want;
            logic [PAGE_BITS-1:0] page;
            int                   slot;
            int unsigned          old_rank;
            page = page_in[PAGE_BITS-1:0];
            want = '0;
            slot = -1;
            for (int i = 0; i < FRAMES; i++) begin
                if (slot < 0 && held[i] && page_of[i] == page) begin
                    slot = i;
                end
            end
            if (slot >= 0) begin
                want.hit = 1'b1;
                hits++;
            end else begin
                // Ranks are a permutation, so exactly one frame is the oldest.
                for (int i = 0; i < FRAMES; i++) begin
                    if (rank[i] == FRAMES - 1) begin
                        slot = i;
                    end
                end
                if (held[slot]) begin
                    want.evicted_valid = 1'b1;
                    want.evicted_page  = OUT_PAGE_W'(page_of[slot]);
                    evictions++;
                end else begin
                    empty_fills++;
                end
                page_of[slot] = page;
                held[slot]    = 1'b1;
                if (fault_total != COUNT_MAX) begin
                    fault_total++;
                end
            end
            old_rank = rank[slot];
            for (int i = 0; i < FRAMES; i++) begin
                if (i != slot && rank[i] < old_rank) begin
                    rank[i]++;
                end
            end
            rank[slot]       = 0;
            want.frame_index = FRAME_IDX_W'(slot);
            want.miss_count  = fault_total;
            expected_outcomes.push_back(want);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: result %0d, %s: expected 0x%0h, actual 0x%0h",
                             $time, checked, field, want, got);
                end
            end
        endfunction

        function void check_outcome(page_outcome_t got);
            page_outcome_t want;
            if (expected_outcomes.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("%0t: unexpected result, expected none, actual %p",
                             $time, got);
                end
                return;
            end
            want = expected_outcomes.pop_front();
            checked++;
            compare_field("hit", 32'(want.hit), 32'(got.hit));
            compare_field("frame_index", 32'(want.frame_index), 32'(got.frame_index));
            compare_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
            compare_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
            compare_field("miss_count", 32'(want.miss_count), 32'(got.miss_count));
        endfunction
    endclass

    logic                   aclk          = 1'b0;
    logic                   aresetn       = 1'b0;
    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [IN_PAGE_W-1:0]   s_page_number = '0;
    logic                   m_valid;
    logic                   m_ready       = 1'b0;
    logic                   m_hit;
    logic [FRAME_IDX_W-1:0] m_frame_index;
    logic                   m_evicted_valid;
    logic [OUT_PAGE_W-1:0]  m_evicted_page;
    logic [COUNT_W-1:0]     m_miss_count;

    lru_frame_board board;
    int unsigned    cycle_count = 0;
    int unsigned    stall_left  = 0;
    int unsigned    rx_roll;
    // When set, the receiver takes every result at once; this gives the run
    // stretches free of back-pressure between the stalled ones.
    bit             rx_steady   = 1'b0;

    lru_page_replacement_top #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_page_number   (s_page_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit),
        .m_frame_index   (m_frame_index),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_page  (m_evicted_page),
        .m_miss_count    (m_miss_count)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Result side. Ready is driven at the rising edge: mostly high, with short
    // stalls fairly often and a long one now and then, so that back-pressure
    // lands on every phase of the block's scan.
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (rx_steady) begin
            m_ready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 3) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(8, 40);
            end else if (rx_roll < 20) begin
                m_ready    <= 1'b0;
                stall_left <= $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result monitor. Outputs are sampled at the edge itself, so the values seen
    // are those that held just before it, whatever order processes run in.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            board.check_outcome({m_hit, m_frame_index, m_evicted_valid,
                                 m_evicted_page, m_miss_count});
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, board.expected_outcomes.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Idle time before an item: usually none or a few cycles, occasionally long.
    function automatic int unsigned pick_gap(bit quiet);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Presents one page reference and waits for the block to take it. Valid is
    // left high after acceptance, so that a following item with no gap keeps it
    // high rather than lowering and raising it in the same time step; callers
    // that stop sending lower it through a gap or through drain_results.
    task automatic send_page(input logic [IN_PAGE_W-1:0] page, input int unsigned gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_page_number <= page;
        do @(posedge aclk); while (!s_ready);
        board.note_access(page);
    endtask

    // Holds the sender back until every predicted result has been taken, then
    // waits out the latency so that any surplus result would still be caught.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.expected_outcomes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [IN_PAGE_W-1:0] pool [POOL_DEPTH];
        logic [IN_PAGE_W-1:0] cycle_pages [FRAMES + 1];
        logic [IN_PAGE_W-1:0] page;
        logic [IN_PAGE_W-1:0] base;
        int unsigned          sent_random;
        int unsigned          block_len;
        int unsigned          pool_size;
        int unsigned          idx;
        bit                   quiet_tx;

        board = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed references, with the receiver never stalling so the early
        // results come back in a predictable rhythm.
        rx_steady <= 1'b1;
        foreach (DIRECTED_PAGES[i]) begin
            send_page(DIRECTED_PAGES[i], (i % 3 == 0) ? 0 : pick_gap(1'b0));
        end
        // The sender pauses here until every result so far has come back.
        drain_results();

        // Random part. Each block works over a small set of pages so that hits,
        // refills and evictions all occur often; sets of up to four pages mostly
        // hit, larger ones force a steady turnover of frames. One reference in
        // seven or so is a page from anywhere in the field, which both breaks
        // up the pattern and exercises every bit of the page number.
        sent_random = 0;
        while (sent_random < RANDOM_ITEMS) begin
            block_len = $urandom_range(20, 60);
            pool_size = $urandom_range(2, 7);
            for (int i = 0; i < POOL_DEPTH; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pool[i] = $urandom_range(0, 1) ? '1 : '0;
                end else begin
                    pool[i] = IN_PAGE_W'($urandom);
                end
            end
            quiet_tx  = ($urandom_range(0, 3) == 0);
            rx_steady <= ($urandom_range(0, 3) == 0);
            for (int k = 0; k < block_len; k++) begin
                if ($urandom_range(0, 99) < 85) begin
                    page = pool[$urandom_range(0, pool_size - 1)];
                end else begin
                    page = IN_PAGE_W'($urandom);
                end
                // Let the working set drift now and then, as a real program's does.
                if ($urandom_range(0, 19) == 0) begin
                    pool[$urandom_range(0, pool_size - 1)] = IN_PAGE_W'($urandom);
                end
                send_page(page, pick_gap(quiet_tx));
                sent_random++;
            end
            if ($urandom_range(0, 5) == 0) begin
                drain_results();
            end
        end
        drain_results();

        // Cycling through one page more than there are frames makes every
        // reference a fault under LRU, so each frame is evicted in turn.
        rx_steady <= 1'b1;
        base = IN_PAGE_W'($urandom);
        for (int i = 0; i <= FRAMES; i++) begin
            cycle_pages[i] = base + IN_PAGE_W'(i);
        end
        idx = 0;
        for (int k = 0; k < 3 * (FRAMES + 1); k++) begin
            send_page(cycle_pages[idx], ($urandom_range(0, 9) == 0) ? 1 : 0);
            idx = (idx + 1) % (FRAMES + 1);
        end
        // The page about to come round next is the only one not resident, so
        // the others all hit.
        for (int k = 1; k <= FRAMES; k++) begin
            send_page(cycle_pages[(idx + k) % (FRAMES + 1)], pick_gap(1'b0));
        end

        // A last stretch of mixed traffic under random back-pressure.
        rx_steady <= 1'b0;
        for (int k = 0; k < 100; k++) begin
            if ($urandom_range(0, 1) == 0) begin
                page = cycle_pages[$urandom_range(0, FRAMES)];
            end else begin
                page = IN_PAGE_W'($urandom);
            end
            send_page(page, pick_gap(1'b0));
        end
        drain_results();

        $display("Checked %0d results: %0d hits, %0d refills of empty frames, %0d evictions.",
                 board.checked, board.hits, board.empty_fills, board.evictions);
        $display("Working sets, random pages and an eviction-every-time pattern left %0d misses.",
                 board.fault_total);
        if (board.failures == 0 && board.expected_outcomes.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
